### design/rtpd_pkg.sv
// Shared types and constants of the RTP H.264 depacketizer.
`timescale 1ns / 1ps

package rtpd_pkg;

    // Packet layout and counter limits.
    localparam logic [15:0] HEADER_BYTES     = 16'd12;
    localparam logic [15:0] FU_HEADER_POS    = HEADER_BYTES + 16'd1;
    localparam logic [15:0] MAX_PACKET_BYTES = 16'd65535;
    localparam logic [15:0] POS_LIMIT        = 16'hFFFF;

    // NAL and RTP header fields.
    localparam logic [1:0] RTP_VERSION = 2'd2;
    localparam logic [4:0] FU_A_TYPE   = 5'd28;

    // Kinds of result words.
    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_DATA_END = 2'd1;
    localparam logic [1:0] KIND_END      = 2'd2;
    localparam logic [1:0] KIND_ABORT    = 2'd3;

    // Command queue between the parser and the emitter.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QPTR_W-1:0] QPTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] QCNT_FULL = QCNT_W'(QUEUE_DEPTH);

    // Order in which the parts of one command leave the block.
    localparam int E_ABORT = 0;
    localparam int E_SC0   = 1;
    localparam int E_SC1   = 2;
    localparam int E_SC2   = 3;
    localparam int E_SC3   = 4;
    localparam int E_HDR   = 5;
    localparam int E_DATA  = 6;
    localparam int E_END   = 7;
    localparam int ELEM_COUNT = 8;

    // Parser mode within the current packet.
    typedef enum logic [3:0] {
        MODE_HEAD   = 4'b0001,
        MODE_SINGLE = 4'b0010,
        MODE_FU     = 4'b0100,
        MODE_DROP   = 4'b1000
    } t_mode;

    // Work that one input word leaves for the emitter.
    typedef struct packed {
        logic       abort;
        logic       start;
        logic       hdr;
        logic [7:0] hdr_byte;
        logic       data;
        logic [7:0] data_byte;
        logic       data_last;
        logic       unit_end;
    } t_cmd;

    // Fill status of the command queue.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

### design/rtpd_front.sv
// Packet parser: tracks the byte position and mode and turns each byte into a command.
`timescale 1ns / 1ps

module rtpd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_in_byte,
    input  logic                i_packet_last,
    input  rtpd_pkg::t_qstat    i_qstat,
    output logic                o_push,
    output rtpd_pkg::t_cmd      o_cmd
);

    logic [15:0]     r_pos,  n_pos;
    rtpd_pkg::t_mode r_mode, n_mode;
    logic [7:0]      r_ind,  n_ind;
    logic            r_fend, n_fend;
    logic            r_open, n_open;
    rtpd_pkg::t_cmd  cmd;
    logic            accept;
    logic            ending;
    logic            close_ok;

    assign o_ready = !i_qstat.full;
    assign accept  = i_valid && o_ready;

    // Classify the byte and work out the next packet state.
    always_comb begin
        n_pos    = r_pos;
        n_mode   = r_mode;
        n_ind    = r_ind;
        n_fend   = r_fend;
        n_open   = r_open;
        cmd      = '0;
        ending   = 1'b0;
        close_ok = 1'b0;

        if (r_pos == '0) begin
            n_mode = (i_in_byte[7:6] == rtpd_pkg::RTP_VERSION) ?
                     rtpd_pkg::MODE_HEAD : rtpd_pkg::MODE_DROP;
            n_fend = 1'b0;
        end else if (r_pos == rtpd_pkg::HEADER_BYTES) begin
            if (r_mode == rtpd_pkg::MODE_HEAD) begin
                n_ind = i_in_byte;
            end
        end else if (r_pos == rtpd_pkg::FU_HEADER_POS) begin
            if (r_mode == rtpd_pkg::MODE_HEAD) begin
                if (r_ind[4:0] == rtpd_pkg::FU_A_TYPE) begin
                    if (i_in_byte[7]) begin
                        // Start fragment: open a unit with the rebuilt NAL header.
                        cmd.abort    = r_open;
                        cmd.start    = 1'b1;
                        cmd.hdr      = 1'b1;
                        cmd.hdr_byte = {r_ind[7:5], i_in_byte[4:0]};
                        n_open       = 1'b1;
                        n_fend       = 1'b0;
                        n_mode       = rtpd_pkg::MODE_FU;
                    end else if (r_open) begin
                        n_fend = i_in_byte[6];
                        n_mode = rtpd_pkg::MODE_FU;
                    end else begin
                        n_mode = rtpd_pkg::MODE_DROP;
                    end
                end else begin
                    // Single NAL unit: start code, NAL header, first data byte.
                    cmd.abort     = r_open;
                    cmd.start     = 1'b1;
                    cmd.hdr       = 1'b1;
                    cmd.hdr_byte  = r_ind;
                    cmd.data      = 1'b1;
                    cmd.data_byte = i_in_byte;
                    cmd.data_last = i_packet_last;
                    n_open        = !i_packet_last;
                    n_mode        = rtpd_pkg::MODE_SINGLE;
                end
            end
        end else if (r_pos > rtpd_pkg::FU_HEADER_POS &&
                     (r_mode == rtpd_pkg::MODE_SINGLE || r_mode == rtpd_pkg::MODE_FU) &&
                     r_pos < rtpd_pkg::MAX_PACKET_BYTES) begin
            // Payload byte of an open unit.
            ending        = (r_mode == rtpd_pkg::MODE_SINGLE) || r_fend;
            cmd.data      = 1'b1;
            cmd.data_byte = i_in_byte;
            if (i_packet_last && ending) begin
                cmd.data_last = 1'b1;
                n_open        = 1'b0;
            end
        end

        if (i_packet_last) begin
            // Close a unit whose final byte was never streamed.
            close_ok = (n_mode == rtpd_pkg::MODE_SINGLE) ||
                       (n_mode == rtpd_pkg::MODE_FU && n_fend);
            if (close_ok && n_open) begin
                cmd.unit_end = 1'b1;
                n_open       = 1'b0;
            end
            n_pos  = '0;
            n_mode = rtpd_pkg::MODE_HEAD;
            n_fend = 1'b0;
        end else if (r_pos < rtpd_pkg::POS_LIMIT) begin
            n_pos = r_pos + 16'd1;
        end
    end

    assign o_cmd  = cmd;
    assign o_push = accept && (cmd.abort || cmd.start || cmd.data || cmd.unit_end);

    // Packet state advances on every accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_mode <= rtpd_pkg::MODE_HEAD;
            r_ind  <= '0;
            r_fend <= 1'b0;
            r_open <= 1'b0;
        end else if (accept) begin
            r_pos  <= n_pos;
            r_mode <= n_mode;
            r_ind  <= n_ind;
            r_fend <= n_fend;
            r_open <= n_open;
        end
    end

endmodule

### design/rtpd_cmd_fifo.sv
// Small command queue that decouples the parser from the emitter.
`timescale 1ns / 1ps

module rtpd_cmd_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rtpd_pkg::t_cmd      i_cmd,
    input  logic                i_pop,
    output rtpd_pkg::t_cmd      o_head,
    output rtpd_pkg::t_qstat    o_qstat
);

    rtpd_pkg::t_cmd                r_mem [rtpd_pkg::QUEUE_DEPTH];
    logic [rtpd_pkg::QPTR_W-1:0]   r_wptr, r_rptr;
    logic [rtpd_pkg::QCNT_W-1:0]   r_count;
    logic                          do_push, do_pop;

    assign o_qstat.full  = (r_count == rtpd_pkg::QCNT_FULL);
    assign o_qstat.empty = (r_count == '0);
    assign do_push       = i_push && !o_qstat.full;
    assign do_pop        = i_pop && !o_qstat.empty;
    assign o_head        = r_mem[r_rptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == rtpd_pkg::QPTR_LAST) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == rtpd_pkg::QPTR_LAST) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### design/rtpd_back.sv
// Emitter: expands queued commands into output words through an output register.
`timescale 1ns / 1ps

module rtpd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rtpd_pkg::t_cmd      i_head,
    input  rtpd_pkg::t_qstat    i_qstat,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_out_byte,
    output logic [1:0]          o_out_kind
);

    logic [rtpd_pkg::ELEM_COUNT-1:0] r_done, n_done;
    logic [rtpd_pkg::ELEM_COUNT-1:0] present, remaining, cur;
    logic                            last_elem, load;
    logic                            r_out_valid;
    logic [7:0]                      r_out_byte, n_byte;
    logic [1:0]                      r_out_kind, n_kind;

    // Parts of the head command still to be sent; take the lowest one.
    always_comb begin
        present                   = '0;
        present[rtpd_pkg::E_ABORT] = i_head.abort;
        present[rtpd_pkg::E_SC0]   = i_head.start;
        present[rtpd_pkg::E_SC1]   = i_head.start;
        present[rtpd_pkg::E_SC2]   = i_head.start;
        present[rtpd_pkg::E_SC3]   = i_head.start;
        present[rtpd_pkg::E_HDR]   = i_head.hdr;
        present[rtpd_pkg::E_DATA]  = i_head.data;
        present[rtpd_pkg::E_END]   = i_head.unit_end;
    end

    assign remaining = present & ~r_done;
    assign cur       = remaining & (~remaining + 1'b1);
    assign last_elem = ((remaining & ~cur) == '0);
    assign load      = !i_qstat.empty && (!r_out_valid || i_ready);
    assign o_pop     = load && last_elem;
    assign n_done    = last_elem ? '0 : (r_done | cur);

    // Word for the selected part.
    always_comb begin
        n_byte = 8'h00;
        n_kind = rtpd_pkg::KIND_END;
        if (cur[rtpd_pkg::E_ABORT]) begin
            n_kind = rtpd_pkg::KIND_ABORT;
        end else if (cur[rtpd_pkg::E_SC0] || cur[rtpd_pkg::E_SC1] || cur[rtpd_pkg::E_SC2]) begin
            n_kind = rtpd_pkg::KIND_DATA;
        end else if (cur[rtpd_pkg::E_SC3]) begin
            n_byte = 8'h01;
            n_kind = rtpd_pkg::KIND_DATA;
        end else if (cur[rtpd_pkg::E_HDR]) begin
            n_byte = i_head.hdr_byte;
            n_kind = rtpd_pkg::KIND_DATA;
        end else if (cur[rtpd_pkg::E_DATA]) begin
            n_byte = i_head.data_byte;
            n_kind = i_head.data_last ? rtpd_pkg::KIND_DATA_END : rtpd_pkg::KIND_DATA;
        end
    end

    // Progress through the head command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_done      <= n_done;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= n_byte;
            r_out_kind <= n_kind;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_out_kind = r_out_kind;

endmodule

### design/rtp_h264_depacketizer.sv
// Top level of the RTP H.264 depacketizer: parser, command queue and emitter.
//
// Input channel: one byte of a decrypted RTP packet per word (i_in_byte), header
// first, with i_packet_last high on the final byte of each packet. Words move
// on i_valid and o_ready. Output channel: one Annex-B stream byte per word
// (o_out_byte) with its kind (o_out_kind: data, data ending the unit, unit end
// without a byte, abort of the open unit), moved on o_valid and i_ready.
// Throughput: the parser takes one input word per cycle while the four-entry
// command queue has room. The emitter sends one output word per cycle while
// i_ready is high; a byte that opens a unit causes up to seven output words.
// The queue takes three more words behind its command, so o_ready can then drop
// until that command is sent. The first output word of an input word is
// written into the queue, then into the output register; earlier queued words
// and a stalled receiver can hold it in between.
// When the receiver stalls, the output register holds its word, the queue
// fills and o_ready drops only once all four entries are taken.
// Reset clears the packet position, mode and open-unit flag, empties the queue
// and drops any pending output word.
`timescale 1ns / 1ps

module rtp_h264_depacketizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_packet_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_out_kind
);

    rtpd_pkg::t_cmd   push_cmd;
    rtpd_pkg::t_cmd   head_cmd;
    rtpd_pkg::t_qstat qstat;
    logic             push;
    logic             pop;

    rtpd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_in_byte     (i_in_byte),
        .i_packet_last (i_packet_last),
        .i_qstat       (qstat),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    rtpd_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_qstat (qstat)
    );

    rtpd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head_cmd),
        .i_qstat    (qstat),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_out_kind (o_out_kind)
    );

endmodule

### design/rtpd_checker.sv
// Port-level checks of the depacketizer and the bind that attaches them.
`timescale 1ns / 1ps

module rtpd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic [7:0] i_in_byte,
    input logic       i_packet_last,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_out_byte,
    input logic [1:0] o_out_kind
);

    // A stalled output word keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte) && $stable(o_out_kind))
        else $error("output word changed while stalled");

    // Unit end and abort words carry a zero byte.
    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out_kind == rtpd_pkg::KIND_END || o_out_kind == rtpd_pkg::KIND_ABORT)
        |-> o_out_byte == 8'h00)
        else $error("marker word with nonzero byte");

    // An abort is always followed at once by the first start code byte.
    a_abort_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_out_kind == rtpd_pkg::KIND_ABORT
        |=> o_valid && o_out_byte == 8'h00 && o_out_kind == rtpd_pkg::KIND_DATA)
        else $error("abort not followed by a start code");

    // Reset leaves no output word pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind rtp_h264_depacketizer rtpd_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .i_in_byte     (i_in_byte),
    .i_packet_last (i_packet_last),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_out_byte    (o_out_byte),
    .o_out_kind    (o_out_kind)
);
